// ===== rtl/core/language_tag_resolver_defines.svh =====
// Assertion macros for the language tag resolver.
`ifndef LANGUAGE_TAG_RESOLVER_DEFINES_SVH
`define LANGUAGE_TAG_RESOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define LTR_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LTR_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTR_ASSERT(label, clk, rstn, prop, msg)
`define LTR_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/ltr_pkg.sv =====
// Shared types, codes and helpers for the language tag resolver.
package ltr_pkg;

  localparam int unsigned MaxVariantsDef = 8;

  localparam logic [3:0] PH_LEAD      = 4'd0;
  localparam logic [3:0] PH_PRIM1     = 4'd1;
  localparam logic [3:0] PH_PRIM2     = 4'd2;
  localparam logic [3:0] PH_EXTLANG   = 4'd3;
  localparam logic [3:0] PH_SCRIPT    = 4'd4;
  localparam logic [3:0] PH_REGION    = 4'd5;
  localparam logic [3:0] PH_VARIANT   = 4'd6;
  localparam logic [3:0] PH_SINGLE    = 4'd7;
  localparam logic [3:0] PH_EXTFIRST  = 4'd8;
  localparam logic [3:0] PH_EXTBODY   = 4'd9;
  localparam logic [3:0] PH_PRIVFIRST = 4'd10;
  localparam logic [3:0] PH_PRIV      = 4'd11;
  localparam logic [3:0] PH_TRAIL     = 4'd12;

  localparam logic [1:0] LANG_NONE    = 2'd0;
  localparam logic [1:0] LANG_ENGLISH = 2'd1;
  localparam logic [1:0] LANG_RUSSIAN = 2'd2;

  localparam logic [1:0] CHOICE_RUSSIAN = 2'd1;
  localparam logic [1:0] CHOICE_ENGLISH = 2'd2;

  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_E    = 8'h65;
  localparam logic [7:0] CH_N    = 8'h6e;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_U    = 8'h75;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_BYTE, OP_END, OP_READ, OP_CMP, OP_VAPPLY, OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    POST_NONE, POST_TRAIL, POST_NEW
  } post_e;

  typedef struct packed {
    op_e op;
  } ltr_cmd_t;

  typedef struct packed {
    logic var_req;     // variant check needed before the step completes
    logic sweep_done;  // store scan finished or duplicate found
    logic last;        // current beat is the final byte
  } ltr_stat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) ? c + 8'd32 : c;
  endfunction

endpackage

// ===== rtl/core/ltr_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ltr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ltr_ctrl.sv =====
// Sequencer for the language tag resolver.
module ltr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_busy_i,
  output logic                out_load_o,
  input  ltr_pkg::ltr_stat_t  stat_i,
  output ltr_pkg::ltr_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BYTE   = 3'd1;
  localparam logic [2:0] S_END    = 3'd2;
  localparam logic [2:0] S_VCHK   = 3'd3;
  localparam logic [2:0] S_VCMP   = 3'd4;
  localparam logic [2:0] S_VAPPLY = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       in_end_q, in_end_d;

  always_comb begin
    state_d    = state_q;
    in_end_d   = in_end_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    cmd_o.op   = ltr_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ltr_pkg::OP_LOAD;
          state_d  = S_BYTE;
        end
      end
      S_BYTE: begin
        cmd_o.op = ltr_pkg::OP_BYTE;
        in_end_d = 1'b0;
        if (stat_i.var_req) begin
          state_d = S_VCHK;
        end else if (stat_i.last) begin
          state_d = S_END;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_END: begin
        cmd_o.op = ltr_pkg::OP_END;
        in_end_d = 1'b1;
        state_d  = stat_i.var_req ? S_VCHK : S_OUT;
      end
      S_VCHK: begin
        if (stat_i.sweep_done) begin
          state_d = S_VAPPLY;
        end else begin
          cmd_o.op = ltr_pkg::OP_READ;
          state_d  = S_VCMP;
        end
      end
      S_VCMP: begin
        cmd_o.op = ltr_pkg::OP_CMP;
        state_d  = S_VCHK;
      end
      S_VAPPLY: begin
        cmd_o.op = ltr_pkg::OP_VAPPLY;
        if (in_end_q) begin
          state_d = S_OUT;
        end else if (stat_i.last) begin
          state_d = S_END;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          cmd_o.op   = ltr_pkg::OP_CLEAR;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      in_end_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_end_q <= in_end_d;
    end
  end

endmodule

// ===== rtl/core/ltr_dp.sv =====
// Datapath: tag parse state, subtag checks and variant store.
module ltr_dp #(
  parameter int unsigned MaxVariants = ltr_pkg::MaxVariantsDef,
  localparam int unsigned Aw  = (MaxVariants > 1) ? $clog2(MaxVariants) : 1,
  localparam int unsigned Vcw = $clog2(MaxVariants + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ltr_pkg::ltr_cmd_t  cmd_i,
  output ltr_pkg::ltr_stat_t stat_o,
  input  logic [7:0]         char_code_i,
  input  logic               last_i,
  input  logic [1:0]         language_choice_i,
  output logic [1:0]         language_o,
  output logic               overflow_o
);

  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [3:0]  phase_q, phase_d;
  logic [1:0]  prim_q, prim_d;
  logic [3:0]  len_q, len_d;
  logic [63:0] chars_q, chars_d;
  logic [2:0]  cls_q, cls_d;
  logic [1:0]  ext_q, ext_d;
  logic [Vcw-1:0] vcnt_q, vcnt_d;
  logic [Vcw-1:0] idx_q, idx_d;
  logic        dup_q, dup_d;
  logic [35:0] smask_q, smask_d;
  logic [1:0]  err_q, err_d;
  ltr_pkg::post_e post_q, post_d;

  logic        ram_we, ram_re;
  logic [67:0] ram_rdata;

  // subtag close
  logic [3:0]  fin_phase;
  logic [1:0]  fin_ext;
  logic [35:0] fin_smask;
  logic        fin_inv, fin_var;
  // tag close
  logic [3:0]  end_phase;
  logic [1:0]  end_ext;
  logic [35:0] end_smask;
  logic        end_inv, end_var;

  logic [7:0]  first_ch, lc;
  logic        var_req;

  assign first_ch = chars_q[7:0];
  assign lc       = ltr_pkg::to_lower(byte_q);

  always_comb begin
    logic       done;
    logic [5:0] bitn;
    fin_phase = phase_q;
    fin_ext   = ext_q;
    fin_smask = smask_q;
    fin_inv   = 1'b0;
    fin_var   = 1'b0;
    done      = 1'b0;
    bitn      = '0;
    if ((len_q == 4'd0) || !cls_q[2]) begin
      fin_inv = 1'b1;
      done    = 1'b1;
    end
    for (int k = 0; k < 6; k++) begin
      if (!done) begin
        case (fin_phase)
          ltr_pkg::PH_EXTLANG: begin
            if ((len_q == 4'd3) && cls_q[0]) begin
              fin_ext = fin_ext + 2'd1;
              if (fin_ext == 2'd3) fin_phase = ltr_pkg::PH_SCRIPT;
              done = 1'b1;
            end else begin
              fin_phase = ltr_pkg::PH_SCRIPT;
            end
          end
          ltr_pkg::PH_SCRIPT: begin
            fin_phase = ltr_pkg::PH_REGION;
            if ((len_q == 4'd4) && cls_q[0]) done = 1'b1;
          end
          ltr_pkg::PH_REGION: begin
            fin_phase = ltr_pkg::PH_VARIANT;
            if (((len_q == 4'd2) && cls_q[0]) || ((len_q == 4'd3) && cls_q[1])) done = 1'b1;
          end
          ltr_pkg::PH_VARIANT: begin
            if ((len_q >= 4'd5) || ((len_q == 4'd4) && ltr_pkg::is_digit(first_ch))) begin
              fin_var = 1'b1;
              done    = 1'b1;
            end else begin
              fin_phase = ltr_pkg::PH_SINGLE;
            end
          end
          ltr_pkg::PH_SINGLE: begin
            done = 1'b1;
            if (len_q != 4'd1) begin
              fin_inv = 1'b1;
            end else if (first_ch == ltr_pkg::CH_X) begin
              fin_phase = ltr_pkg::PH_PRIVFIRST;
            end else begin
              bitn = ltr_pkg::is_digit(first_ch) ? 6'(first_ch - 8'h30)
                                                 : 6'(first_ch - 8'h61 + 8'd10);
              if ((fin_smask & (36'd1 << bitn)) != '0) begin
                fin_inv = 1'b1;
              end else begin
                fin_smask = fin_smask | (36'd1 << bitn);
                fin_phase = ltr_pkg::PH_EXTFIRST;
              end
            end
          end
          ltr_pkg::PH_EXTFIRST: begin
            done = 1'b1;
            if (len_q >= 4'd2) fin_phase = ltr_pkg::PH_EXTBODY;
            else fin_inv = 1'b1;
          end
          ltr_pkg::PH_EXTBODY: begin
            if (len_q >= 4'd2) done = 1'b1;
            else fin_phase = ltr_pkg::PH_SINGLE;
          end
          ltr_pkg::PH_PRIVFIRST: begin
            fin_phase = ltr_pkg::PH_PRIV;
            done      = 1'b1;
          end
          ltr_pkg::PH_PRIV: done = 1'b1;
          default: begin
            fin_inv = 1'b1;
            done    = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    end_phase = phase_q;
    end_ext   = ext_q;
    end_smask = smask_q;
    end_inv   = 1'b0;
    end_var   = 1'b0;
    if (!err_q[0]) begin
      if ((phase_q == ltr_pkg::PH_LEAD) || (phase_q == ltr_pkg::PH_PRIM1)) begin
        end_inv = 1'b1;
      end else if ((phase_q != ltr_pkg::PH_PRIM2) && (phase_q != ltr_pkg::PH_TRAIL)) begin
        end_phase = fin_phase;
        end_ext   = fin_ext;
        end_smask = fin_smask;
        end_var   = fin_var;
        end_inv   = fin_inv || (!fin_var && ((fin_phase == ltr_pkg::PH_EXTFIRST) ||
                                             (fin_phase == ltr_pkg::PH_PRIVFIRST)));
      end
    end
  end

  always_comb begin
    byte_d  = byte_q;
    last_d  = last_q;
    phase_d = phase_q;
    prim_d  = prim_q;
    len_d   = len_q;
    chars_d = chars_q;
    cls_d   = cls_q;
    ext_d   = ext_q;
    vcnt_d  = vcnt_q;
    idx_d   = idx_q;
    dup_d   = dup_q;
    smask_d = smask_q;
    err_d   = err_q;
    post_d  = post_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    var_req = 1'b0;
    case (cmd_i.op)
      ltr_pkg::OP_LOAD: begin
        byte_d = char_code_i;
        last_d = last_i;
      end
      ltr_pkg::OP_BYTE: begin
        if (!err_q[0]) begin
          if (ltr_pkg::is_blank(byte_q)) begin
            if ((phase_q != ltr_pkg::PH_LEAD) && (phase_q != ltr_pkg::PH_TRAIL)) begin
              phase_d  = end_phase;
              ext_d    = end_ext;
              smask_d  = end_smask;
              err_d[0] = end_inv;
              if (end_var) begin
                var_req = 1'b1;
                post_d  = ltr_pkg::POST_TRAIL;
                idx_d   = '0;
                dup_d   = 1'b0;
              end else begin
                phase_d = ltr_pkg::PH_TRAIL;
              end
            end
          end else begin
            case (phase_q)
              ltr_pkg::PH_LEAD: begin
                chars_d = {56'd0, lc};
                phase_d = ltr_pkg::PH_PRIM1;
              end
              ltr_pkg::PH_PRIM1: begin
                if ((first_ch == ltr_pkg::CH_E) && (lc == ltr_pkg::CH_N)) begin
                  prim_d = ltr_pkg::LANG_ENGLISH;
                end else if ((first_ch == ltr_pkg::CH_R) && (lc == ltr_pkg::CH_U)) begin
                  prim_d = ltr_pkg::LANG_RUSSIAN;
                end else begin
                  err_d[0] = 1'b1;
                end
                chars_d = '0;
                phase_d = ltr_pkg::PH_PRIM2;
              end
              ltr_pkg::PH_PRIM2: begin
                if (byte_q == ltr_pkg::CH_DASH) begin
                  len_d   = '0;
                  chars_d = '0;
                  cls_d   = 3'b111;
                  phase_d = ltr_pkg::PH_EXTLANG;
                end else begin
                  err_d[0] = 1'b1;
                end
              end
              ltr_pkg::PH_TRAIL: err_d[0] = 1'b1;
              default: begin
                if (byte_q == ltr_pkg::CH_DASH) begin
                  phase_d  = fin_phase;
                  ext_d    = fin_ext;
                  smask_d  = fin_smask;
                  err_d[0] = fin_inv;
                  if (fin_var) begin
                    var_req = 1'b1;
                    post_d  = ltr_pkg::POST_NEW;
                    idx_d   = '0;
                    dup_d   = 1'b0;
                  end else begin
                    len_d   = '0;
                    chars_d = '0;
                    cls_d   = 3'b111;
                  end
                end else if (len_q[3]) begin
                  err_d[0] = 1'b1;
                end else begin
                  if (ltr_pkg::is_alpha(byte_q)) cls_d = cls_q & 3'b101;
                  else if (ltr_pkg::is_digit(byte_q)) cls_d = cls_q & 3'b110;
                  else cls_d = 3'b000;
                  chars_d = chars_q | ({56'd0, lc} << {len_q[2:0], 3'b000});
                  len_d   = len_q + 4'd1;
                end
              end
            endcase
          end
        end
      end
      ltr_pkg::OP_END: begin
        phase_d = end_phase;
        ext_d   = end_ext;
        smask_d = end_smask;
        if (end_inv) err_d[0] = 1'b1;
        if (end_var) begin
          var_req = 1'b1;
          post_d  = ltr_pkg::POST_NONE;
          idx_d   = '0;
          dup_d   = 1'b0;
        end
      end
      ltr_pkg::OP_READ: ram_re = 1'b1;
      ltr_pkg::OP_CMP: begin
        if (ram_rdata == {len_q, chars_q}) dup_d = 1'b1;
        idx_d = idx_q + Vcw'(1);
      end
      ltr_pkg::OP_VAPPLY: begin
        if (dup_q) begin
          err_d[0] = 1'b1;
        end else if (vcnt_q >= Vcw'(MaxVariants)) begin
          err_d = 2'b11;
        end else begin
          ram_we = 1'b1;
          vcnt_d = vcnt_q + Vcw'(1);
        end
        case (post_q)
          ltr_pkg::POST_TRAIL: phase_d = ltr_pkg::PH_TRAIL;
          ltr_pkg::POST_NEW: begin
            len_d   = '0;
            chars_d = '0;
            cls_d   = 3'b111;
          end
          default: ;
        endcase
      end
      ltr_pkg::OP_CLEAR: begin
        phase_d = ltr_pkg::PH_LEAD;
        prim_d  = ltr_pkg::LANG_NONE;
        len_d   = '0;
        chars_d = '0;
        cls_d   = 3'b111;
        ext_d   = '0;
        vcnt_d  = '0;
        smask_d = '0;
        err_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= 1'b0;
      phase_q <= ltr_pkg::PH_LEAD;
      prim_q  <= ltr_pkg::LANG_NONE;
      len_q   <= '0;
      chars_q <= '0;
      cls_q   <= 3'b111;
      ext_q   <= '0;
      vcnt_q  <= '0;
      idx_q   <= '0;
      dup_q   <= 1'b0;
      smask_q <= '0;
      err_q   <= '0;
      post_q  <= ltr_pkg::POST_NONE;
    end else begin
      last_q  <= last_d;
      phase_q <= phase_d;
      prim_q  <= prim_d;
      len_q   <= len_d;
      chars_q <= chars_d;
      cls_q   <= cls_d;
      ext_q   <= ext_d;
      vcnt_q  <= vcnt_d;
      idx_q   <= idx_d;
      dup_q   <= dup_d;
      smask_q <= smask_d;
      err_q   <= err_d;
      post_q  <= post_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  ltr_ram #(
    .Width(68),
    .Depth(MaxVariants)
  ) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (vcnt_q[Aw-1:0]),
    .wdata_i ({len_q, chars_q}),
    .re_i    (ram_re),
    .raddr_i (idx_q[Aw-1:0]),
    .rdata_o (ram_rdata)
  );

  assign stat_o.var_req    = var_req;
  assign stat_o.sweep_done = dup_q || (idx_q == vcnt_q);
  assign stat_o.last       = last_q;

  always_comb begin
    if (language_choice_i == ltr_pkg::CHOICE_RUSSIAN) begin
      language_o = ltr_pkg::LANG_RUSSIAN;
      overflow_o = 1'b0;
    end else if (language_choice_i == ltr_pkg::CHOICE_ENGLISH) begin
      language_o = ltr_pkg::LANG_ENGLISH;
      overflow_o = 1'b0;
    end else begin
      language_o = err_q[0] ? ltr_pkg::LANG_NONE : prim_q;
      overflow_o = err_q[1];
    end
  end

endmodule

// ===== rtl/core/language_tag_resolver.sv =====
// Language tag resolver: byte stream in, one language result beat per tag.
// A byte is accepted, then parsed; the last byte adds a tag close and then the result load.
// A variant subtag close scans the variant RAM with one read per stored entry, then checks
// for a duplicate and applies the variant.
// A new byte is taken only once the previous one, and any variant close or result load, is done.
// Reset: rst_ni async low clears parse state, the choice register and the output valid.
module language_tag_resolver #(
  parameter int unsigned MaxVariants = ltr_pkg::MaxVariantsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,   // last byte of tag
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [1:0] language, [2] overflow, [7:3] zero
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "language_tag_resolver_defines.svh"

  logic [1:0] choice_q;
  logic       out_valid_q;
  logic [1:0] out_lang_q;
  logic       out_ovf_q;

  ltr_pkg::ltr_cmd_t  cmd;
  ltr_pkg::ltr_stat_t stat;
  logic       out_load, out_busy;
  logic [1:0] res_lang;
  logic       res_ovf;
  logic       ovf_with_lang;

  // Single register, choice at byte 0.
  assign pready = 1'b1;
  assign prdata = {30'd0, choice_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      choice_q <= '0;
    end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
      choice_q <= pwdata[1:0];
    end
  end

  // Result register: the parser keeps taking bytes while a result waits.
  assign out_busy = out_valid_q && !m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_lang_q <= res_lang;
      out_ovf_q  <= res_ovf;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_ovf_q, out_lang_q};

  ltr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_busy_i (out_busy),
    .out_load_o (out_load),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ltr_dp #(
    .MaxVariants(MaxVariants)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .char_code_i       (s_axis_tdata_i),
    .last_i            (s_axis_tlast_i),
    .language_choice_i (choice_q),
    .language_o        (res_lang),
    .overflow_o        (res_ovf)
  );

  // overflow always comes with an invalid tag
  assign ovf_with_lang = out_ovf_q && (out_lang_q != ltr_pkg::LANG_NONE);

  `LTR_ASSERT(a_no_overwrite, clk_i, rst_ni, out_load |-> !out_busy, "result overwritten")
  `LTR_ASSERT(a_ovf_none, clk_i, rst_ni, m_axis_tvalid_o |-> !ovf_with_lang, "overflow with language")
  `LTR_ASSERT(a_lang_code, clk_i, rst_ni, m_axis_tvalid_o |-> (out_lang_q != 2'd3), "bad language code")

endmodule

// ===== dv/language_tag_resolver_checker.sv =====
// Checker for the language tag resolver: watches the streams and config writes, predicts results.
`timescale 1ns / 100ps
module language_tag_resolver_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [0:0] REG_LANG_CHOICE = 1'b0;
  localparam int unsigned VAR_SLOTS = 8;

  typedef struct packed {
    logic [1:0] language;
    logic       overflow;
  } verdict_t;

  verdict_t   verdicts_q[$];
  logic [1:0] choice;

  // tag parse state
  logic [3:0]  ph;
  logic [1:0]  prim;
  logic [3:0]  seg_len;
  logic [63:0] seg_chars;
  logic        all_alpha, all_digit, all_alnum;
  logic [1:0]  ext_cnt;
  logic [63:0] var_chars[VAR_SLOTS];
  logic [3:0]  var_len[VAR_SLOTS];
  logic [4:0]  var_cnt;
  logic [35:0] single_seen;
  logic        bad, ovfl;

  function automatic logic blank_c(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction
  function automatic logic letter_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic numeral_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic [7:0] fold_c(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function void new_seg();
    seg_len = '0; seg_chars = '0;
    all_alpha = 1'b1; all_digit = 1'b1; all_alnum = 1'b1;
  endfunction

  function void clear_tag();
    ph = ltr_pkg::PH_LEAD; prim = ltr_pkg::LANG_NONE; ext_cnt = '0; var_cnt = '0;
    single_seen = '0; bad = 1'b0; ovfl = 1'b0;
    new_seg();
  endfunction

  function void keep_variant();
    for (int i = 0; i < var_cnt; i++)
      if (var_len[i] == seg_len && var_chars[i] == seg_chars) begin
        bad = 1'b1;
        return;
      end
    if (var_cnt >= VAR_SLOTS) begin
      bad = 1'b1; ovfl = 1'b1;
      return;
    end
    var_chars[var_cnt] = seg_chars;
    var_len[var_cnt] = seg_len;
    var_cnt++;
  endfunction

  // closes one subtag, walking forward through optional slots
  function void close_seg();
    logic [7:0] first;
    int idx;
    first = seg_chars[7:0];
    if (seg_len == 0 || !all_alnum) begin
      bad = 1'b1;
      return;
    end
    forever begin
      case (ph)
        ltr_pkg::PH_EXTLANG: begin
          if (seg_len == 3 && all_alpha) begin
            ext_cnt++;
            if (ext_cnt == 2'd3) ph = ltr_pkg::PH_SCRIPT;
            return;
          end
          ph = ltr_pkg::PH_SCRIPT;
        end
        ltr_pkg::PH_SCRIPT: begin
          ph = ltr_pkg::PH_REGION;
          if (seg_len == 4 && all_alpha) return;
        end
        ltr_pkg::PH_REGION: begin
          ph = ltr_pkg::PH_VARIANT;
          if ((seg_len == 2 && all_alpha) || (seg_len == 3 && all_digit)) return;
        end
        ltr_pkg::PH_VARIANT: begin
          if (seg_len >= 5 || (seg_len == 4 && numeral_c(first))) begin
            keep_variant();
            return;
          end
          ph = ltr_pkg::PH_SINGLE;
        end
        ltr_pkg::PH_SINGLE: begin
          if (seg_len != 1) begin
            bad = 1'b1;
            return;
          end
          if (first == ltr_pkg::CH_X) begin
            ph = ltr_pkg::PH_PRIVFIRST;
          end else begin
            idx = numeral_c(first) ? int'(first - 8'h30) : int'(first - 8'h61) + 10;
            if (single_seen[idx]) begin
              bad = 1'b1;
              return;
            end
            single_seen[idx] = 1'b1;
            ph = ltr_pkg::PH_EXTFIRST;
          end
          return;
        end
        ltr_pkg::PH_EXTFIRST: begin
          if (seg_len >= 2) ph = ltr_pkg::PH_EXTBODY;
          else bad = 1'b1;
          return;
        end
        ltr_pkg::PH_EXTBODY: begin
          if (seg_len >= 2) return;
          ph = ltr_pkg::PH_SINGLE;
        end
        ltr_pkg::PH_PRIVFIRST: begin
          ph = ltr_pkg::PH_PRIV;
          return;
        end
        ltr_pkg::PH_PRIV: return;
        default: begin
          bad = 1'b1;
          return;
        end
      endcase
    end
  endfunction

  function void close_tag();
    if (bad) return;
    if (ph == ltr_pkg::PH_LEAD || ph == ltr_pkg::PH_PRIM1) begin
      bad = 1'b1;
      return;
    end
    if (ph == ltr_pkg::PH_PRIM2 || ph == ltr_pkg::PH_TRAIL) return;
    close_seg();
    if (ph == ltr_pkg::PH_EXTFIRST || ph == ltr_pkg::PH_PRIVFIRST) bad = 1'b1;
  endfunction

  function void parse_byte(logic [7:0] c);
    logic [7:0] a;
    if (bad) return;
    if (blank_c(c)) begin
      if (ph != ltr_pkg::PH_LEAD && ph != ltr_pkg::PH_TRAIL) begin
        close_tag();
        ph = ltr_pkg::PH_TRAIL;
      end
      return;
    end
    case (ph)
      ltr_pkg::PH_LEAD: begin
        seg_chars = {56'd0, fold_c(c)};
        ph = ltr_pkg::PH_PRIM1;
        return;
      end
      ltr_pkg::PH_PRIM1: begin
        a = seg_chars[7:0];
        if (a == ltr_pkg::CH_E && fold_c(c) == ltr_pkg::CH_N) prim = ltr_pkg::LANG_ENGLISH;
        else if (a == ltr_pkg::CH_R && fold_c(c) == ltr_pkg::CH_U) prim = ltr_pkg::LANG_RUSSIAN;
        else bad = 1'b1;
        seg_chars = '0;
        ph = ltr_pkg::PH_PRIM2;
        return;
      end
      ltr_pkg::PH_PRIM2: begin
        if (c == ltr_pkg::CH_DASH) begin
          new_seg();
          ph = ltr_pkg::PH_EXTLANG;
        end else begin
          bad = 1'b1;
        end
        return;
      end
      ltr_pkg::PH_TRAIL: begin
        bad = 1'b1;
        return;
      end
      default: ;
    endcase
    if (c == ltr_pkg::CH_DASH) begin
      close_seg();
      new_seg();
      return;
    end
    if (seg_len >= 8) begin
      bad = 1'b1;
      return;
    end
    if (letter_c(c)) all_digit = 1'b0;
    else if (numeral_c(c)) all_alpha = 1'b0;
    else {all_alpha, all_digit, all_alnum} = 3'b000;
    seg_chars |= {56'd0, fold_c(c)} << (8 * seg_len);
    seg_len++;
  endfunction

  function verdict_t tag_verdict();
    verdict_t v;
    if (choice == ltr_pkg::CHOICE_RUSSIAN) v = '{ltr_pkg::LANG_RUSSIAN, 1'b0};
    else if (choice == ltr_pkg::CHOICE_ENGLISH) v = '{ltr_pkg::LANG_ENGLISH, 1'b0};
    else v = '{bad ? ltr_pkg::LANG_NONE : prim, ovfl};
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      choice = '0;
      clear_tag();
      verdicts_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_LANG_CHOICE)
        choice = pwdata[1:0];
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        parse_byte(s_axis_tdata_i);
        if (s_axis_tlast_i) begin
          close_tag();
          verdicts_q.push_back(tag_verdict());
          clear_tag();
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (verdicts_q.size() == 0) begin
          $error("result beat with no tag outstanding: %h", m_axis_tdata_i);
          fail_count_o++;
        end else begin
          exp_v = verdicts_q.pop_front();
          if (m_axis_tdata_i[1:0] !== exp_v.language) begin
            $error("language: expected %0d, actual %0d", exp_v.language, m_axis_tdata_i[1:0]);
            fail_count_o++;
          end
          if (m_axis_tdata_i[2] !== exp_v.overflow) begin
            $error("overflow: expected %0d, actual %0d", exp_v.overflow, m_axis_tdata_i[2]);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = verdicts_q.size();
  end

endmodule

// ===== dv/tb_language_tag_resolver.sv =====
// Testbench top for the language tag resolver: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_language_tag_resolver;

  localparam logic [1:0] CHOICE_FROM_TAG = 2'd0;
  localparam logic [1:0] CHOICE_SPARE    = 2'd3;  // unused code, resolves like from-tag
  localparam logic [0:0] REG_LANG_CHOICE = 1'b0;
  localparam int RANDOM_BYTES = 770;    // directed tags bring the total near 950
  localparam int STALL_LIMIT  = 4000;   // cycles without any beat or config access
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int SETTLE       = 40;     // exceeds the worst variant close plus tag close

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [7:0] char_code
  logic        s_axis_tlast = 1'b0;   // last byte of tag
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // [1:0] language, [2] overflow
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending;
  int bytes_sent;
  int quiet_cycles;
  bit burst;       // both sides run without gaps while set
  bit long_hold;   // receiver request for one long hold-off

  language_tag_resolver uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata), .s_axis_tlast_i(s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o(m_axis_tdata),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  language_tag_resolver_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata), .s_axis_tlast_i(s_axis_tlast),
    .m_axis_tvalid_i(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i(m_axis_tdata),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: any beat or config access resets the quiet counter.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result receiver. Handshake signals are sampled right after the edge,
  // so they hold their pre-edge values.
  initial begin
    int hold;
    forever begin
      if (long_hold) hold = HOLD_CYCLES;
      else hold = burst ? 0 : $urandom_range(0, 10);
      long_hold = 1'b0;
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_tag(input byte unsigned t[$]);
    int gap;
    for (int i = 0; i < t.size(); i++) begin
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= t[i];
      s_axis_tlast  <= (i == t.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      bytes_sent++;
    end
  endtask

  task automatic send_text(input string s);
    byte unsigned t[$];
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_tag(t);
  endtask

  // Drain all results, then let a trailing non-last byte finish its work.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_choice(input logic [1:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_LANG_CHOICE; pwdata <= {30'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic byte unsigned rand_char(input int kind);
    int k;
    k = (kind == 2) ? $urandom_range(0, 1) : kind;
    if (k == 1) return 8'(8'h30 + $urandom_range(0, 9));
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
  endfunction

  // kind: 0 letters, 1 digits, 2 mixed
  function automatic void put_seg(ref byte unsigned t[$], input int len, input int kind);
    t.push_back(ltr_pkg::CH_DASH);
    for (int i = 0; i < len; i++) t.push_back(rand_char(kind));
  endfunction

  function automatic void put_blanks(ref byte unsigned t[$]);
    byte unsigned blanks[4] = '{8'h20, 8'h09, 8'h0d, 8'h0a};
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      t.push_back(blanks[$urandom_range(0, 3)]);
  endfunction

  // Mostly well-formed tags with random content, then some corruption.
  function automatic void build_tag(ref byte unsigned t[$]);
    int vpos[$], vlen[$];
    int nv, pos, len;
    byte unsigned sg, last_sg;
    t = {};
    put_blanks(t);
    case ($urandom_range(0, 9))
      0:       begin t.push_back(rand_char(0)); t.push_back(rand_char(0)); end
      1, 2, 3: begin t.push_back(ltr_pkg::CH_R ^ 8'($urandom_range(0, 1) << 5));
                     t.push_back(ltr_pkg::CH_U ^ 8'($urandom_range(0, 1) << 5)); end
      default: begin t.push_back(ltr_pkg::CH_E ^ 8'($urandom_range(0, 1) << 5));
                     t.push_back(ltr_pkg::CH_N ^ 8'($urandom_range(0, 1) << 5)); end
    endcase
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0) put_seg(t, 3, 0);
    if ($urandom_range(0, 1)) put_seg(t, 4, 0);
    case ($urandom_range(0, 2))
      0: put_seg(t, 2, 0);
      1: put_seg(t, 3, 1);
      default: ;
    endcase
    nv = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 2);
    repeat (nv) begin
      if (vpos.size() > 0 && $urandom_range(0, 7) == 0) begin
        // duplicate of an earlier variant, case flipped at random
        pos = $urandom_range(0, vpos.size() - 1);
        t.push_back(ltr_pkg::CH_DASH);
        for (int i = 0; i < vlen[pos]; i++)
          t.push_back(t[vpos[pos] + i] ^ ((t[vpos[pos] + i] >= 8'h41) ?
                      8'($urandom_range(0, 1) << 5) : 8'h00));
      end else begin
        len = $urandom_range(4, 8);
        vpos.push_back(t.size() + 1);
        vlen.push_back(len);
        put_seg(t, len, 2);
        if (len == 4) t[t.size() - 4] = rand_char(1);
      end
    end
    last_sg = "a";
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 5) == 0) sg = last_sg;
      else begin
        sg = rand_char(2);
        if (sg == "x" || sg == "X") sg = "y";
      end
      last_sg = sg;
      t.push_back(ltr_pkg::CH_DASH);
      t.push_back(sg);
      repeat ($urandom_range(0, 8) == 0 ? 0 : $urandom_range(1, 2))
        put_seg(t, $urandom_range(2, 8), 2);
    end
    if ($urandom_range(0, 3) == 0) begin
      t.push_back(ltr_pkg::CH_DASH);
      t.push_back($urandom_range(0, 1) ? ltr_pkg::CH_X : 8'h58);
      repeat ($urandom_range(0, 8) == 0 ? 0 : $urandom_range(1, 2))
        put_seg(t, $urandom_range(1, 8), 2);
    end
    put_blanks(t);
    // noise: wrong byte, overlong subtag, or truncation
    case ($urandom_range(0, 9))
      0, 1: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
      2:    repeat ($urandom_range(1, 4)) t.push_back(rand_char(2));
      3:    while (t.size() > 1 && $urandom_range(0, 3) != 0) void'(t.pop_back());
      default: ;
    endcase
  endfunction

  initial begin
    byte unsigned t[$];
    logic [1:0] settings[4] = '{ltr_pkg::CHOICE_RUSSIAN, ltr_pkg::CHOICE_ENGLISH,
                                CHOICE_SPARE, CHOICE_FROM_TAG};
    int phase_idx;
    int target;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_choice(CHOICE_FROM_TAG);

    // directed tags: primaries, every subtag slot, and invalid cases
    send_text("en");
    send_text("RU");
    send_text(" ");
    send_text("\ten-US\r\n");
    send_text("ru-Cyrl-RU");
    send_text("eN-abc-def-ghi-Latn-419-1996-abcde-a-bc-x-yz");
    send_text("en x");
    send_text("en-abcdefghi");
    send_text("en-u$s");
    send_text("en-abcde-ABCDE");
    send_text("en-a-bc-a-de");
    send_text("en-a");
    send_text("ru-x");
    send_text("zz");
    send_text("en-aaaaa-bbbbb-ccccc-ddddd-eeeee-fffff-ggggg-hhhhh-iiiii");
    drain();

    // random phases over every register setting, extremes included
    bytes_sent = 0;
    long_hold = 1'b1;
    for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
      write_choice(settings[phase_idx]);
      target = (phase_idx + 1) * RANDOM_BYTES / 4;
      while (bytes_sent < target) begin
        burst = ($urandom_range(0, 5) == 0);
        build_tag(t);
        send_tag(t);
      end
      burst = 1'b0;
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ltr_pkg.sv
rtl/core/ltr_ram.sv
rtl/core/ltr_ctrl.sv
rtl/core/ltr_dp.sv
rtl/core/language_tag_resolver.sv
dv/language_tag_resolver_checker.sv
dv/tb_language_tag_resolver.sv
